/* sv/indexed_list_engine_assert.svh */
// assertion macros for the indexed list engine modules
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ILE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ILE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/ile_pkg.sv */
// shared types and codes of the indexed list engine
package ile_pkg;

   localparam int VALUE_W  = 10;
   localparam int READ_W   = 11;
   localparam int STATUS_W = 2;
   localparam int LENGTH_W = 9;
   localparam int OP_W     = 3;
   localparam int INDEX_W  = 8;

   localparam logic [OP_W-1:0] OP_GET  = 3'd0;
   localparam logic [OP_W-1:0] OP_HEAD = 3'd1;
   localparam logic [OP_W-1:0] OP_TAIL = 3'd2;
   localparam logic [OP_W-1:0] OP_AT   = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL  = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   localparam logic signed [READ_W-1:0] READ_MISS = -11'sd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GET,
      ST_INS,
      ST_FILL,
      ST_DEL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic signed [READ_W-1:0] read_value;
      logic [STATUS_W-1:0]      status;
      logic [LENGTH_W-1:0]      list_length;
   } res_type;

endpackage

/* sv/ile_ram.sv */
// generic single-write single-read ram with registered read data
module ile_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/ile_ctrl.sv */
// sequencer that walks the list memory for get, insert and delete
module ile_ctrl #(
   parameter int CAPACITY = 256,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [ile_pkg::OP_W-1:0]      req_operation,
   input  logic [ile_pkg::INDEX_W-1:0]   req_index,
   input  logic [ile_pkg::VALUE_W-1:0]   req_value,
   output logic                          req_stall,
   output logic                          res_valid,
   output ile_pkg::res_type              res,
   input  logic                          res_take,
   output logic                          ram_we,
   output logic [AW-1:0]                 ram_waddr,
   output logic [ile_pkg::VALUE_W-1:0]   ram_wdata,
   output logic [AW-1:0]                 ram_raddr,
   input  logic [ile_pkg::VALUE_W-1:0]   ram_rdata
);

`include "indexed_list_engine_assert.svh"

   ile_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [ile_pkg::VALUE_W-1:0] val_ff, val_in;
   logic signed [ile_pkg::READ_W-1:0] rd_ff, rd_in;
   logic [ile_pkg::STATUS_W-1:0] st_ff, st_in;
   logic [31:0] idx32, cnt32, ins32;

   assign idx32 = 32'(req_index);
   assign cnt32 = 32'(count_ff);

   // target position of an insert
   always_comb begin
      if (req_operation == ile_pkg::OP_HEAD) begin
         ins32 = 32'd0;
      end else if (req_operation == ile_pkg::OP_TAIL) begin
         ins32 = cnt32;
      end else begin
         ins32 = idx32;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ile_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      pos_ff <= pos_in;
      val_ff <= val_in;
      rd_ff  <= rd_in;
      st_ff  <= st_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      rd_in     = rd_ff;
      st_in     = st_ff;
      ram_we    = 1'b0;
      ram_waddr = ptr_ff;
      ram_wdata = ram_rdata;
      ram_raddr = '0;
      unique case (state_ff)
         ile_pkg::ST_IDLE: begin
            if (req_valid) begin
               rd_in    = ile_pkg::READ_MISS;
               st_in    = ile_pkg::STAT_DONE;
               val_in   = req_value;
               state_in = ile_pkg::ST_RESP;
               unique case (req_operation) inside
                  ile_pkg::OP_GET: begin
                     if (idx32 < cnt32) begin
                        ram_raddr = AW'(req_index);
                        state_in  = ile_pkg::ST_GET;
                     end else begin
                        st_in = ile_pkg::STAT_RANGE;
                     end
                  end
                  ile_pkg::OP_HEAD, ile_pkg::OP_TAIL, ile_pkg::OP_AT: begin
                     if (ins32 > cnt32) begin
                        st_in = ile_pkg::STAT_RANGE;
                     end else if (cnt32 >= 32'(CAPACITY)) begin
                        st_in = ile_pkg::STAT_FULL;
                     end else if (ins32 == cnt32) begin
                        // append needs no shift
                        ram_we    = 1'b1;
                        ram_waddr = AW'(count_ff);
                        ram_wdata = req_value;
                        count_in  = count_ff + CW'(1);
                     end else begin
                        pos_in    = AW'(ins32);
                        ptr_in    = AW'(count_ff);
                        ram_raddr = AW'(cnt32 - 32'd1);
                        state_in  = ile_pkg::ST_INS;
                     end
                  end
                  ile_pkg::OP_DEL: begin
                     if (idx32 >= cnt32) begin
                        st_in = ile_pkg::STAT_RANGE;
                     end else if (idx32 + 32'd1 == cnt32) begin
                        // last entry goes without a shift
                        count_in = count_ff - CW'(1);
                     end else begin
                        ptr_in    = AW'(req_index);
                        ram_raddr = AW'(idx32 + 32'd1);
                        state_in  = ile_pkg::ST_DEL;
                     end
                  end
                  default: begin
                     st_in = ile_pkg::STAT_RANGE;
                  end
               endcase
            end
         end
         ile_pkg::ST_GET: begin
            rd_in    = $signed({1'b0, ram_rdata});
            state_in = ile_pkg::ST_RESP;
         end
         ile_pkg::ST_INS: begin
            // move entry ptr-1 up to ptr while fetching ptr-2
            ram_we    = 1'b1;
            ram_waddr = ptr_ff;
            ram_wdata = ram_rdata;
            if (32'(ptr_ff) == 32'(pos_ff) + 32'd1) begin
               state_in = ile_pkg::ST_FILL;
            end else begin
               ram_raddr = AW'(32'(ptr_ff) - 32'd2);
               ptr_in    = AW'(32'(ptr_ff) - 32'd1);
            end
         end
         ile_pkg::ST_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = val_ff;
            count_in  = count_ff + CW'(1);
            state_in  = ile_pkg::ST_RESP;
         end
         ile_pkg::ST_DEL: begin
            // move entry ptr+1 down to ptr while fetching ptr+2
            ram_we    = 1'b1;
            ram_waddr = ptr_ff;
            ram_wdata = ram_rdata;
            if (32'(ptr_ff) + 32'd2 == cnt32) begin
               count_in = count_ff - CW'(1);
               state_in = ile_pkg::ST_RESP;
            end else begin
               ram_raddr = AW'(32'(ptr_ff) + 32'd2);
               ptr_in    = AW'(32'(ptr_ff) + 32'd1);
            end
         end
         ile_pkg::ST_RESP: begin
            if (res_take) begin
               state_in = ile_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ile_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall       = (state_ff != ile_pkg::ST_IDLE);
   assign res_valid       = (state_ff == ile_pkg::ST_RESP);
   assign res.read_value  = rd_ff;
   assign res.status      = st_ff;
   assign res.list_length = ile_pkg::LENGTH_W'(count_ff);

   `ILE_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, 32'(count_ff) <= 32'(CAPACITY), "list length above capacity")
   `ILE_ASSERT_IMPLY(a_ins_ptr, clock, reset, state_ff == ile_pkg::ST_INS, 32'(ptr_ff) > 32'(pos_ff), "insert shift passed its target")
   `ILE_ASSERT_IMPLY(a_del_ptr, clock, reset, state_ff == ile_pkg::ST_DEL, 32'(ptr_ff) + 32'd2 <= cnt32, "delete shift ran past the end")
   `ILE_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, state_ff != ile_pkg::ST_IDLE, "accepted request left engine idle")

endmodule

/* sv/indexed_list_engine.sv */
// indexed list engine top level: list memory, sequencer and result register
// get reads memory in ST_GET before ST_RESP; append or tail delete go straight to ST_RESP
// insert at p: ST_INS moves entries up, one memory move per cycle, then ST_FILL writes it
// delete at p: ST_DEL moves the entries above p down, one memory move per cycle
// one request in flight; the next is accepted once the result sits in the output register
// synchronous reset empties the list; memory contents are left as they were
module indexed_list_engine #(
   parameter int CAPACITY = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ile_pkg::OP_W-1:0]             req_operation,
   input  logic [ile_pkg::INDEX_W-1:0]          req_index,
   input  logic [ile_pkg::VALUE_W-1:0]          req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [ile_pkg::READ_W-1:0]    rsp_read_value,
   output logic [ile_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ile_pkg::LENGTH_W-1:0]         rsp_list_length
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic                          ram_we;
   logic [AW-1:0]                 ram_waddr;
   logic [ile_pkg::VALUE_W-1:0]   ram_wdata;
   logic [AW-1:0]                 ram_raddr;
   logic [ile_pkg::VALUE_W-1:0]   ram_rdata;
   logic                          res_valid;
   logic                          res_take;
   ile_pkg::res_type              res;
   logic                          rsp_valid_ff, rsp_valid_in;
   ile_pkg::res_type              rsp_ff, rsp_in;

   ile_ram #(
      .WIDTH (ile_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ile_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_index     (req_index),
      .req_value     (req_value),
      .req_stall     (req_stall),
      .res_valid     (res_valid),
      .res           (res),
      .res_take      (res_take),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata)
   );

   // output register loads when empty or being drained
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_ff.read_value;
   assign rsp_status      = rsp_ff.status;
   assign rsp_list_length = rsp_ff.list_length;

endmodule
